// File: sv/setsp_pkg.sv
package setsp_pkg;

   localparam int unsigned DIST_W  = 16;
   localparam int unsigned WIDTH_W = 8;
   localparam int unsigned PCNT_W  = 9;
   localparam int unsigned CSR_IDX_W = 2;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_C = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE   = 2'd3;

   // reset values of the registers
   localparam logic [WIDTH_W-1:0] SERVO_A_RESET = 8'd30;
   localparam logic [WIDTH_W-1:0] SERVO_B_RESET = 8'd31;
   localparam logic [WIDTH_W-1:0] SERVO_C_RESET = 8'd22;
   localparam logic [DIST_W-1:0]  RANGE_RESET   = 16'd600;

   localparam logic [DIST_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [DIST_W-1:0] distance_ticks;
      logic              distance_updated;
      logic              measuring;
   } echo_result_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width_a;
      logic [WIDTH_W-1:0] width_b;
      logic [WIDTH_W-1:0] width_c;
   } servo_widths_type;

endpackage

// File: sv/setsp_echo_timer.sv
module setsp_echo_timer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           echo_level,
   input  logic                           arm_request,
   input  logic [setsp_pkg::DIST_W-1:0]   range_limit,
   output setsp_pkg::echo_result_type     result
);

   logic                         armed_ff, armed_in;
   logic                         seen_ff, seen_in;
   logic [setsp_pkg::DIST_W-1:0] count_ff, count_in;
   logic [setsp_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic                         updated;

   always_comb begin
      armed_in = armed_ff | arm_request;
      seen_in  = seen_ff;
      count_in = count_ff;
      dist_in  = dist_ff;
      updated  = 1'b0;
      if (armed_in) begin
         if (echo_level) begin
            seen_in = 1'b1;
         end else if (seen_ff) begin
            // falling edge ends the measurement
            seen_in  = 1'b0;
            armed_in = 1'b0;
            if (count_ff < range_limit) begin
               dist_in = count_ff;
               updated = 1'b1;
            end
            count_in = '0;
         end
         if (seen_in && (count_in != setsp_pkg::COUNT_MAX)) begin
            count_in = count_in + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
         dist_ff  <= '0;
      end else if (step) begin
         armed_ff <= armed_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
         dist_ff  <= dist_in;
      end
   end

   assign result.distance_ticks   = dist_in;
   assign result.distance_updated = updated;
   assign result.measuring        = armed_in;

endmodule

// File: sv/setsp_servo_pwm.sv
module setsp_servo_pwm #(
   parameter int unsigned PWM_PERIOD = 400
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  setsp_pkg::servo_widths_type widths,
   output logic [2:0]                  levels
);

   localparam logic [setsp_pkg::PCNT_W-1:0] PERIOD_LAST =
      setsp_pkg::PCNT_W'(PWM_PERIOD);

   logic [setsp_pkg::PCNT_W-1:0] pcnt_ff, pcnt_in, pcnt_inc;
   logic [2:0]                   levels_ff, levels_in;
   logic                         wrap;

   always_comb begin
      pcnt_inc  = pcnt_ff + 1'b1;
      wrap      = (pcnt_inc == PERIOD_LAST);
      pcnt_in   = wrap ? '0 : pcnt_inc;
      levels_in = wrap ? 3'b111 : levels_ff;
      if (pcnt_in == {1'b0, widths.width_a}) levels_in[0] = 1'b0;
      if (pcnt_in == {1'b0, widths.width_b}) levels_in[1] = 1'b0;
      if (pcnt_in == {1'b0, widths.width_c}) levels_in[2] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff   <= '0;
         levels_ff <= '0;
      end else if (step) begin
         pcnt_ff   <= pcnt_in;
         levels_ff <= levels_in;
      end
   end

   assign levels = levels_in;

`ifndef SYNTH
   // the period counter stays inside one period
   a_pcnt_range: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff < PERIOD_LAST)
      else $error("pwm period counter out of range");
`endif

endmodule

// File: sv/sonar_echo_timer_servo_pwm_unit.sv
// sonar echo timer with three servo pwm outputs
//
// one req word is one timer tick: the sampled echo pin and an arm flag that
// marks a trigger pulse just sent. each req word yields exactly one rsp word
// with the three servo levels, the last accepted distance in ticks, a flag
// for a freshly captured distance and the still-measuring flag.
// a req word passes through the input register and then the result
// register before it is presented on rsp; a word can be accepted every
// cycle while req_stall is low.
// the tick logic is a single pass of counters and compares between them.
// req_stall rises only while both the input register and the result
// register are full and rsp_stall is high; the rsp word then holds.
// csr writes (csr_write_en, csr_index, csr_wdata) take effect at the edge
// and are meant for when the block is idle.
// reset (synchronous, active high) disarms the measurement, clears the
// pulse counter, distance, pwm counter, pwm levels and the valid flags,
// and reloads the register defaults; the rsp servo outputs are not reset.
module sonar_echo_timer_servo_pwm_unit #(
   parameter int unsigned PWM_PERIOD = 400
) (
   input  logic                              clock,
   input  logic                              reset,
   // tick input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_echo_level,
   input  logic                              req_arm_request,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_servo_a_out,
   output logic                              rsp_servo_b_out,
   output logic                              rsp_servo_c_out,
   output logic [setsp_pkg::DIST_W-1:0]      rsp_distance_ticks,
   output logic                              rsp_distance_updated,
   output logic                              rsp_measuring,
   // register write port
   input  logic                              csr_write_en,
   input  logic [setsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [setsp_pkg::DIST_W-1:0]      csr_wdata
);

   // configuration registers
   setsp_pkg::servo_widths_type  widths_ff;
   logic [setsp_pkg::DIST_W-1:0] range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         widths_ff.width_a <= setsp_pkg::SERVO_A_RESET;
         widths_ff.width_b <= setsp_pkg::SERVO_B_RESET;
         widths_ff.width_c <= setsp_pkg::SERVO_C_RESET;
         range_ff          <= setsp_pkg::RANGE_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            setsp_pkg::CSR_SERVO_A: widths_ff.width_a <= csr_wdata[setsp_pkg::WIDTH_W-1:0];
            setsp_pkg::CSR_SERVO_B: widths_ff.width_b <= csr_wdata[setsp_pkg::WIDTH_W-1:0];
            setsp_pkg::CSR_SERVO_C: widths_ff.width_c <= csr_wdata[setsp_pkg::WIDTH_W-1:0];
            setsp_pkg::CSR_RANGE:   range_ff          <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: the tick advances from the input register into the
   // result register whenever the result register is free or being taken
   logic in_valid_ff;
   logic in_echo_ff;
   logic in_arm_ff;
   logic out_valid_ff;
   logic out_free;
   logic advance;
   logic req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_echo_ff <= req_echo_level;
         in_arm_ff  <= req_arm_request;
      end
   end

   // tick logic, state moves only when a tick advances
   setsp_pkg::echo_result_type echo_res;
   logic [2:0]                 servo_levels;

   setsp_echo_timer u_echo (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .echo_level  (in_echo_ff),
      .arm_request (in_arm_ff),
      .range_limit (range_ff),
      .result      (echo_res)
   );

   setsp_servo_pwm #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_pwm (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .widths (widths_ff),
      .levels (servo_levels)
   );

   // result register
   setsp_pkg::echo_result_type out_echo_ff;
   logic [2:0]                 out_levels_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_echo_ff   <= echo_res;
         out_levels_ff <= servo_levels;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_servo_a_out      = out_levels_ff[0];
   assign rsp_servo_b_out      = out_levels_ff[1];
   assign rsp_servo_c_out      = out_levels_ff[2];
   assign rsp_distance_ticks   = out_echo_ff.distance_ticks;
   assign rsp_distance_updated = out_echo_ff.distance_updated;
   assign rsp_measuring        = out_echo_ff.measuring;

`ifndef SYNTH
   // a captured distance always ends the measurement
   a_update_disarms: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_echo_ff.distance_updated |-> !out_echo_ff.measuring)
      else $error("distance captured while still measuring");

   // input is held back only when the result register is full and stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> out_valid_ff && rsp_stall && in_valid_ff)
      else $error("input stalled without a stalled result");

   // an advancing tick always lands in the result register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("tick lost between input and result register");

   // a captured distance is reported in that word and lies below the range limit
   a_update_value: assert property (@(posedge clock) disable iff (reset)
      advance && echo_res.distance_updated |=>
         out_echo_ff.distance_updated && out_echo_ff.distance_ticks < $past(range_ff))
      else $error("captured distance not below range limit");
`endif

endmodule
